FILE: rtl/itoa_pkg.sv
// Shared widths, constants, job type and digit encoding for the radix text converter.
package itoa_pkg;

	localparam int VALUE_BITS = 32;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 7;
	localparam int DIV_STEPS  = 8;
	localparam int DIV_CYC    = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int PAD_W      = DIV_CYC * DIV_STEPS;
	localparam int IDX_W      = $clog2(VALUE_BITS);
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int STEP_W     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] DEC_DIGITS  = RADIX_W'(10);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(8'h41);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2D);
	localparam logic [CHAR_W-1:0] CHAR_NUL   = CHAR_W'(0);

	typedef struct packed {
		logic [VALUE_BITS-1:0] mag;
		logic [RADIX_W-1:0]    radix;
		logic                  neg;
		logic                  bad;
	} job_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_DIGITS) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
		end
		return c;
	endfunction

endpackage

FILE: rtl/itoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/itoa_fifo.sv
// Two-entry job queue between the front end and the conversion engine.
module itoa_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  itoa_pkg::job_t     wr_job,
	output logic               is_full,
	input  logic               rd_en,
	output itoa_pkg::job_t     rd_job,
	output logic               is_empty
);

	itoa_pkg::job_t ent_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;

	assign is_full  = (cnt_q == 2'd2);
	assign is_empty = (cnt_q == 2'd0);
	assign rd_job   = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wptr_q <= ~wptr_q;
			end
			if (rd_en) begin
				rptr_q <= ~rptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/itoa_front.sv
// Front end: radix register, input word capture and classification into jobs.
module itoa_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [itoa_pkg::RADIX_W-1:0]          radix,
	output logic                                  job_push,
	output itoa_pkg::job_t                        job,
	input  logic                                  job_full
);

	logic [itoa_pkg::RADIX_W-1:0] radix_q;
	itoa_pkg::job_t               job_s1;
	logic                         vld_s1;
	itoa_pkg::job_t               cls;
	logic                         accept;

	assign cfg_ready = 1'b1;
	assign job_push  = vld_s1 && !job_full;
	assign full      = vld_s1 && job_full;
	assign accept    = push && !full;
	assign job       = job_s1;

	always_comb begin
		cls.neg   = value[itoa_pkg::VALUE_BITS-1];
		cls.mag   = cls.neg ? (~value + itoa_pkg::VALUE_BITS'(1)) : value;
		cls.radix = radix_q;
		cls.bad   = (radix_q < itoa_pkg::RADIX_MIN) || (radix_q > itoa_pkg::RADIX_MAX);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itoa_pkg::RADIX_RESET;
			vld_s1  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radix_q <= radix;
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (job_push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/itoa_back.sv
// Conversion engine: repeated division by the radix, digit stack and character output.
module itoa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_empty,
	input  itoa_pkg::job_t                job,
	output logic                          job_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [itoa_pkg::CHAR_W-1:0]   character,
	output logic                          is_last,
	output logic                          bad_radix
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ERR,
		ST_SIGN,
		ST_RD,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [itoa_pkg::PAD_W-1:0]      q_q;
	logic [itoa_pkg::RADIX_W-1:0]    r_q;
	logic [itoa_pkg::RADIX_W-1:0]    rad_q;
	logic                            neg_q;
	logic [itoa_pkg::STEP_W-1:0]     step_q;
	logic [itoa_pkg::CNT_W-1:0]      cnt_q;
	logic [itoa_pkg::IDX_W-1:0]      idx_q;
	logic                            out_vld_q;
	logic [itoa_pkg::CHAR_W-1:0]     char_q;
	logic                            last_q;
	logic                            bad_q;

	logic [itoa_pkg::PAD_W-1:0]      q_n;
	logic [itoa_pkg::RADIX_W-1:0]    r_n;
	logic [itoa_pkg::RADIX_W:0]      t;
	logic [itoa_pkg::RADIX_W:0]      diff;
	logic                            last_step;
	logic                            we;
	logic [itoa_pkg::RADIX_W-1:0]    rdata;
	logic                            out_free;
	logic                            emit;

	// Restoring division, DIV_STEPS quotient bits per cycle
	always_comb begin
		r_n  = r_q;
		q_n  = q_q;
		t    = '0;
		diff = '0;
		for (int i = 0; i < itoa_pkg::DIV_STEPS; i++) begin
			t    = {r_n, q_n[itoa_pkg::PAD_W-1]};
			diff = t - {1'b0, rad_q};
			if (t >= {1'b0, rad_q}) begin
				r_n = diff[itoa_pkg::RADIX_W-1:0];
				q_n = {q_n[itoa_pkg::PAD_W-2:0], 1'b1};
			end else begin
				r_n = t[itoa_pkg::RADIX_W-1:0];
				q_n = {q_n[itoa_pkg::PAD_W-2:0], 1'b0};
			end
		end
	end

	assign last_step = (step_q == itoa_pkg::STEP_W'(itoa_pkg::DIV_CYC - 1));
	assign we        = (state_q == ST_DIV) && last_step;
	assign job_pop   = (state_q == ST_IDLE) && !job_empty;
	assign out_free  = !out_vld_q || pop;
	// a new output word is loaded in the error, sign and digit states
	assign emit      = out_free && ((state_q == ST_ERR) || (state_q == ST_SIGN) ||
			(state_q == ST_EMIT));
	assign empty     = !out_vld_q;
	assign character = char_q;
	assign is_last   = last_q;
	assign bad_radix = bad_q;

	itoa_ram #(
		.WIDTH(itoa_pkg::RADIX_W),
		.DEPTH(itoa_pkg::VALUE_BITS)
	) u_digits (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[itoa_pkg::IDX_W-1:0]),
		.wdata(r_n),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			q_q       <= '0;
			r_q       <= '0;
			rad_q     <= '0;
			neg_q     <= 1'b0;
			step_q    <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
			char_q    <= itoa_pkg::CHAR_NUL;
			last_q    <= 1'b0;
			bad_q     <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						q_q    <= itoa_pkg::PAD_W'(job.mag);
						r_q    <= '0;
						rad_q  <= job.radix;
						neg_q  <= job.neg;
						step_q <= '0;
						cnt_q  <= '0;
						state_q <= job.bad ? ST_ERR : ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_step) begin
						cnt_q  <= cnt_q + itoa_pkg::CNT_W'(1);
						step_q <= '0;
						r_q    <= '0;
						q_q    <= itoa_pkg::PAD_W'(q_n[itoa_pkg::VALUE_BITS-1:0]);
						if (q_n == '0) begin
							idx_q   <= cnt_q[itoa_pkg::IDX_W-1:0];
							state_q <= neg_q ? ST_SIGN : ST_RD;
						end
					end else begin
						step_q <= step_q + itoa_pkg::STEP_W'(1);
						r_q    <= r_n;
						q_q    <= q_n;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						char_q    <= itoa_pkg::CHAR_NUL;
						last_q    <= 1'b1;
						bad_q     <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						char_q    <= itoa_pkg::CHAR_MINUS;
						last_q    <= 1'b0;
						bad_q     <= 1'b0;
						state_q   <= ST_RD;
					end
				end
				ST_RD: begin
					// read data for idx_q lands next cycle
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						char_q    <= itoa_pkg::digit_char(rdata);
						last_q    <= (idx_q == '0);
						bad_q     <= 1'b0;
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q - itoa_pkg::IDX_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/integer_to_radix_ascii_unit.sv
// Top level of the signed integer to radix text converter.
// Each input word is a signed VALUE_BITS value; it comes out as ASCII characters in the base
// held in the radix register (2 to 36, reset 10; written over the cfg channel, always ready):
// a leading '-' for negative values, then the digits most significant first, 'A'..'Z' above
// nine, is_last on the final character. A base outside 2..36 gives one word with character 0,
// is_last and bad_radix set. The front end classifies words into a two-entry job queue, so up
// to three words can be taken while a conversion runs. The engine converts one word at a
// time: each digit comes from a full division by the radix in the divider, which retires
// eight quotient bits a cycle, and the characters are then read back from the digit RAM,
// most significant digit first, through its registered read.
module integer_to_radix_ascii_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [itoa_pkg::RADIX_W-1:0]          radix,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [itoa_pkg::CHAR_W-1:0]           character,
	output logic                                  is_last,
	output logic                                  bad_radix
);

	itoa_pkg::job_t wr_job;
	itoa_pkg::job_t rd_job;
	logic           job_push;
	logic           job_full;
	logic           job_pop;
	logic           job_empty;

	itoa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.value    (value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.radix    (radix),
		.job_push (job_push),
		.job      (wr_job),
		.job_full (job_full)
	);

	itoa_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (wr_job),
		.is_full (job_full),
		.rd_en   (job_pop),
		.rd_job  (rd_job),
		.is_empty(job_empty)
	);

	itoa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job      (rd_job),
		.job_pop  (job_pop),
		.empty    (empty),
		.pop      (pop),
		.character(character),
		.is_last  (is_last),
		.bad_radix(bad_radix)
	);

endmodule

FILE: tb/sv/integer_to_radix_ascii_unit_test.sv
// Self-checking testbench for the radix text converter: directed table, then randomized phases.
module integer_to_radix_ascii_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 250;
	localparam int TEXT_CHARS  = 12;
	localparam int ROW_COUNT   = 23;
	localparam int PHASES      = 16;
	localparam int PHASE_WORDS = 25;
	localparam int CALM_PHASE  = 13;

	typedef struct packed {
		logic [itoa_pkg::CHAR_W-1:0] ch;
		logic                        last;
		logic                        bad;
	} text_word_t;

	typedef enum logic [1:0] {ROW_MODEL, ROW_TEXT, ROW_BAD} row_kind_t;

	typedef struct packed {
		logic [itoa_pkg::RADIX_W-1:0]    base;
		logic [itoa_pkg::VALUE_BITS-1:0] num;
		row_kind_t                       kind;
		logic [8*TEXT_CHARS-1:0]         text;
	} directed_row_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n;
	logic                                   push;
	logic                                   full;
	logic signed [itoa_pkg::VALUE_BITS-1:0] value;
	logic                                   cfg_valid;
	logic                                   cfg_ready;
	logic [itoa_pkg::RADIX_W-1:0]           radix;
	logic                                   empty;
	logic                                   pop;
	logic [itoa_pkg::CHAR_W-1:0]            character;
	logic                                   is_last;
	logic                                   bad_radix;

	text_word_t                   expected_text[$];
	logic [itoa_pkg::RADIX_W-1:0] base_now;
	bit                           calm;
	int                           mismatch_count;
	int                           words_seen;
	int                           idle_cycles;

	directed_row_t stim_rows [ROW_COUNT] = '{
		'{6'd10, 32'h0000_0000, ROW_TEXT,  "0"},
		'{6'd10, 32'h7FFF_FFFF, ROW_TEXT,  "2147483647"},
		'{6'd10, 32'h8000_0000, ROW_TEXT,  "-2147483648"},
		'{6'd10, 32'hFFFF_FFFF, ROW_TEXT,  "-1"},
		'{6'd10, 32'h0000_0009, ROW_TEXT,  "9"},
		'{6'd10, 32'h0000_3039, ROW_MODEL, ""},
		'{6'd10, 32'hFFFF_CFC7, ROW_MODEL, ""},
		'{6'd2,  32'h8000_0000, ROW_MODEL, ""},
		'{6'd2,  32'h7FFF_FFFF, ROW_MODEL, ""},
		'{6'd2,  32'hFFFF_FFFF, ROW_TEXT,  "-1"},
		'{6'd2,  32'h0000_0000, ROW_TEXT,  "0"},
		'{6'd36, 32'h0000_0023, ROW_TEXT,  "Z"},
		'{6'd36, 32'h0000_0024, ROW_TEXT,  "10"},
		'{6'd36, 32'h7FFF_FFFF, ROW_MODEL, ""},
		'{6'd36, 32'h8000_0000, ROW_MODEL, ""},
		'{6'd16, 32'hDEAD_BEEF, ROW_MODEL, ""},
		'{6'd16, 32'h0000_00FF, ROW_TEXT,  "FF"},
		'{6'd0,  32'h0000_0005, ROW_BAD,   ""},
		'{6'd1,  32'hFFFF_FFF9, ROW_BAD,   ""},
		'{6'd37, 32'h0000_0000, ROW_BAD,   ""},
		'{6'd63, 32'h7FFF_FFFF, ROW_BAD,   ""},
		'{6'd3,  32'h8000_0000, ROW_MODEL, ""},
		'{6'd10, 32'h0000_0064, ROW_TEXT,  "100"}
	};

	integer_to_radix_ascii_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.radix     (radix),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.is_last   (is_last),
		.bad_radix (bad_radix)
	);

	always #2 clk = ~clk;

	// Append the characters that one value gives in the given base.
	function automatic void convert_to_text(input logic [itoa_pkg::VALUE_BITS-1:0] num,
			input logic [itoa_pkg::RADIX_W-1:0] base);
		logic [itoa_pkg::VALUE_BITS-1:0] mag;
		logic [itoa_pkg::RADIX_W-1:0]    digit_buf [itoa_pkg::VALUE_BITS];
		logic [itoa_pkg::RADIX_W-1:0]    d;
		logic [itoa_pkg::CHAR_W-1:0]     ch;
		int                              n;
		if (base < itoa_pkg::RADIX_MIN || base > itoa_pkg::RADIX_MAX) begin
			expected_text.push_back('{itoa_pkg::CHAR_NUL, 1'b1, 1'b1});
			return;
		end
		mag = num[itoa_pkg::VALUE_BITS-1] ? (~num + 1'b1) : num;
		n = 0;
		do begin
			digit_buf[n] = itoa_pkg::RADIX_W'(mag % base);
			n++;
			mag = mag / base;
		end while (mag != 0);
		if (num[itoa_pkg::VALUE_BITS-1])
			expected_text.push_back('{itoa_pkg::CHAR_MINUS, 1'b0, 1'b0});
		for (int i = n - 1; i >= 0; i--) begin
			d = digit_buf[i];
			if (d < itoa_pkg::DEC_DIGITS)
				ch = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(d);
			else
				ch = itoa_pkg::CHAR_A + itoa_pkg::CHAR_W'(d - itoa_pkg::DEC_DIGITS);
			expected_text.push_back('{ch, i == 0, 1'b0});
		end
	endfunction

	task automatic send_word(input logic [itoa_pkg::VALUE_BITS-1:0] num, input bit predicted);
		if (!calm && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		push  <= 1'b1;
		value <= num;
		do @(posedge clk); while (full);
		if (predicted)
			convert_to_text(num, base_now);
	endtask

	// Drain every pending word, then write the base register.
	task automatic set_base(input logic [itoa_pkg::RADIX_W-1:0] b);
		push <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		radix     <= b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_now = b;
	endtask

	initial begin
		logic [7:0]                      c;
		logic [itoa_pkg::VALUE_BITS-1:0] num;
		logic [itoa_pkg::RADIX_W-1:0]    b;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		value     <= '0;
		cfg_valid <= 1'b0;
		radix     <= itoa_pkg::RADIX_RESET;
		base_now = itoa_pkg::RADIX_RESET;
		calm = 1'b0;
		mismatch_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < ROW_COUNT; r++) begin
			// Last row rewrites the reset base explicitly.
			if (stim_rows[r].base != base_now || r == ROW_COUNT - 1)
				set_base(stim_rows[r].base);
			send_word(stim_rows[r].num, stim_rows[r].kind == ROW_MODEL);
			if (stim_rows[r].kind == ROW_BAD) begin
				expected_text.push_back('{itoa_pkg::CHAR_NUL, 1'b1, 1'b1});
			end else if (stim_rows[r].kind == ROW_TEXT) begin
				for (int k = TEXT_CHARS - 1; k >= 0; k--) begin
					c = stim_rows[r].text[k*8 +: 8];
					if (c != 8'h00)
						expected_text.push_back('{c[itoa_pkg::CHAR_W-1:0], k == 0, 1'b0});
				end
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 7))
				0: b = itoa_pkg::RADIX_MIN;
				1: b = itoa_pkg::RADIX_MAX;
				2: b = $urandom_range(0, 1) ? itoa_pkg::RADIX_W'($urandom_range(0, 1))
						: itoa_pkg::RADIX_W'($urandom_range(37, 63));
				default: b = itoa_pkg::RADIX_W'($urandom_range(2, 36));
			endcase
			set_base(b);
			calm = (ph >= CALM_PHASE);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: num = $urandom;
					5, 6: num = $urandom_range(0, 99);
					7: begin
						case ($urandom_range(0, 4))
							0: num = 32'h0000_0000;
							1: num = 32'h8000_0000;
							2: num = 32'h7FFF_FFFF;
							3: num = 32'hFFFF_FFFF;
							default: num = 32'h0000_0001;
						endcase
					end
					default: num = $urandom >> $urandom_range(0, 31);
				endcase
				if ($urandom_range(0, 3) == 0)
					num = ~num + 1'b1;
				send_word(num, 1'b1);
			end
		end

		push <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		mismatch_count += expected_text.size();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Result side: check each accepted word, stall pop in random bursts outside the calm phases.
	initial begin
		text_word_t got;
		text_word_t want;
		int         stall_left;
		stall_left = 0;
		words_seen = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				got = '{character, is_last, bad_radix};
				if (expected_text.size() == 0) begin
					if (mismatch_count < 10)
						$display("word %0d: unexpected char %h last %b bad %b",
							words_seen, got.ch, got.last, got.bad);
					mismatch_count++;
				end else begin
					want = expected_text.pop_front();
					if (got.ch !== want.ch || got.last !== want.last ||
							got.bad !== want.bad) begin
						if (mismatch_count < 10)
							$display({"word %0d: expected char %h last %b bad %b, ",
								"got char %h last %b bad %b"},
								words_seen, want.ch, want.last, want.bad,
								got.ch, got.last, got.bad);
						mismatch_count++;
					end
				end
				words_seen++;
			end
			if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 17);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Abort when no handshake of any kind completes for too long.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule
